>>> rtl/eaq_pkg.sv
// shared constants, types and table functions for the euler angle to quaternion core
`default_nettype none

package eaq_pkg;

    // fixed field widths
    localparam int ANGLE_W = 16;
    localparam int OUT_W   = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;

    // phase resolution and fraction bits of the trig values
    localparam int PHASE_BITS = 12;
    localparam int FRAC_BITS  = 15;

    localparam int QUARTER   = 1 << (PHASE_BITS - 2);
    localparam int TBL_DEPTH = QUARTER + 1;
    localparam int ADDR_W    = PHASE_BITS - 1;
    localparam int SIN_W     = FRAC_BITS + 1;
    localparam int SUM_W     = FRAC_BITS + 2;
    localparam longint AMP   = (longint'(1) <<< FRAC_BITS) - 1;

    // one full turn of the half-angle in degree units: 720 degrees times 64
    localparam int DEG_UNITS     = 64;
    localparam int HALF_TURN_DEG = 180;
    localparam int HALF_DIV      = 2;
    localparam int DEG_TURN      = HALF_TURN_DEG * HALF_DIV * HALF_DIV * DEG_UNITS;
    localparam int TURN_SHIFT    = 10;
    localparam int TURN_ODD      = DEG_TURN >> TURN_SHIFT;

    // floor division by the turn: shift by the power of two, then reciprocal multiply
    localparam int OFF_W       = ANGLE_W + 1;
    localparam int SCALED_W    = OFF_W + PHASE_BITS;
    localparam int QUOT_W      = SCALED_W - TURN_SHIFT;
    localparam int RECIP_SHIFT = QUOT_W + $clog2(TURN_ODD) + 1;
    localparam int RECIP_W     = RECIP_SHIFT - $clog2(TURN_ODD) + 1;
    localparam int PROD_W      = QUOT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(TURN_ODD) - 64'd1) / 64'(TURN_ODD));
    localparam logic [OFF_W-1:0] ANGLE_OFFSET = OFF_W'(DEG_TURN);

    localparam logic [63:0] PIHALF_Q60 = 64'h1921FB54442D1846;

    localparam int NUM_STAGES = 5;

    typedef logic [FRAC_BITS-1:0] sine_tbl_t [TBL_DEPTH];

    // per-stage load enables of the pipeline
    typedef struct packed {
        logic phase;
        logic trig;
        logic pair;
        logic triple;
        logic sum;
    } stage_en_t;

    // signed value over a positive divisor, rounded toward zero, by shift and subtract
    function automatic longint div_trunc(input longint num, input longint den);
        logic [63:0] mag;
        logic [63:0] dvs;
        logic [63:0] quo;
        logic [64:0] rem;
        mag = (num < 0) ? 64'(-num) : 64'(num);
        dvs = 64'(den);
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], mag[b]};
            if (rem >= {1'b0, dvs})
            begin
                rem = rem - {1'b0, dvs};
                quo[b] = 1'b1;
            end
        end
        return (num < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    // sin(pi/2 * k / QUARTER) in Q30 by a Taylor series, evaluated at elaboration
    function automatic longint sine_q30(input int unsigned k);
        logic [63:0] xu;
        longint x;
        longint x2;
        longint sum;
        longint term;
        xu = (64'(k) * (PIHALF_Q60 >> 14) + (64'd1 << (PHASE_BITS + 13)))
             >> (PHASE_BITS + 14);
        x    = longint'(xu);
        x2   = longint'((xu * xu) >> 30);
        sum  = x;
        term = x;
        for (int n = 1; n <= 14; n++)
        begin
            term = -(term * x2) / 64'sd1073741824;
            term = div_trunc(term, longint'((2 * n) * (2 * n + 1)));
            sum  = sum + term;
        end
        if (sum < 0)
            sum = 0;
        if (sum > 64'sd1073741824)
            sum = 64'sd1073741824;
        return sum;
    endfunction

    // filled in blocks of 32 entries to keep each loop short
    function automatic sine_tbl_t build_sine_tbl();
        sine_tbl_t tbl;
        longint s;
        int k;
        for (int hi = 0; hi <= (TBL_DEPTH >> 5); hi++)
        begin
            for (int lo = 0; lo < 32; lo++)
            begin
                k = (hi << 5) + lo;
                if (k < TBL_DEPTH)
                begin
                    s = sine_q30(k);
                    tbl[k] = FRAC_BITS'((s * AMP + 64'sd536870912) >>> 30);
                end
            end
        end
        return tbl;
    endfunction

    // clamp to +-AMP and wrap into the 16-bit output field
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] amp_s;
        logic signed [SUM_W-1:0] c;
        logic signed [63:0] wide;
        amp_s = SUM_W'(AMP);
        c = v;
        if (v > amp_s)
            c = amp_s;
        if (v < -amp_s)
            c = -amp_s;
        wide = 64'(c);
        return wide[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/euler_angles_to_quaternion_core.sv
// top level: euler angles in, rotation quaternion out, five-stage pipeline
//
// input channel s_axis: one item carries roll, yaw and pitch in degrees times 64,
// signed; any 16-bit pattern is taken, the half-angle phase wraps every 720 degrees.
// output channel m_axis: one item per input item, w, x, y, z in Q1.15, saturated
// to +-32767, in input order.
// stages in order: phase multiply, sine rom read, pair multiply, triple multiply, sum.
// throughput: one item per cycle while m_axis_tready is high; every stage has its
// own valid bit and load enable, so a bubble anywhere lets a new item in while a
// result waits.
// stall: when m_axis_tready is low the output item holds; items behind it close
// up, and s_axis_tready drops only once all five stages hold an item.
// reset: rst_n clears the valid bits only; the pipeline is empty afterward and the
// sine rom is constant, so the first item may follow right away.
`default_nettype none

module euler_angles_to_quaternion_core
    import eaq_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]    s_axis_tdata,   // roll_deg, yaw_deg, pitch_deg
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    output logic [OUT_DATA_W-1:0]        m_axis_tdata    // quat_w, quat_x, quat_y, quat_z
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] load;
    stage_en_t             stage_en;

    logic signed [ANGLE_W-1:0] roll_deg, yaw_deg, pitch_deg;
    logic [PHASE_BITS-1:0]     roll_ph, yaw_ph, pitch_ph;
    logic signed [SIN_W-1:0]   s1, c1, s2, c2, s3, c3;
    logic [OUT_W-1:0]          quat_w, quat_x, quat_y, quat_z;

    // a stage loads when it is empty or its item moves on
    always_comb
    begin
        load[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_axis_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
            load[i] = !valid_reg[i] || load[i+1];
        valid_next[0] = load[0] ? s_axis_tvalid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
            valid_next[i] = load[i] ? valid_reg[i-1] : valid_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    always_comb
    begin
        stage_en.phase  = load[0];
        stage_en.trig   = load[1];
        stage_en.pair   = load[2];
        stage_en.triple = load[3];
        stage_en.sum    = load[4];
    end

    assign roll_deg  = s_axis_tdata[0 +: ANGLE_W];
    assign yaw_deg   = s_axis_tdata[ANGLE_W +: ANGLE_W];
    assign pitch_deg = s_axis_tdata[2*ANGLE_W +: ANGLE_W];

    eaq_phase u_phase_roll (
        .clk   (clk),
        .en    (stage_en.phase),
        .angle (roll_deg),
        .phase (roll_ph)
    );

    eaq_phase u_phase_yaw (
        .clk   (clk),
        .en    (stage_en.phase),
        .angle (yaw_deg),
        .phase (yaw_ph)
    );

    eaq_phase u_phase_pitch (
        .clk   (clk),
        .en    (stage_en.phase),
        .angle (pitch_deg),
        .phase (pitch_ph)
    );

    // index 1 is yaw, 2 is pitch, 3 is roll
    eaq_trig u_trig_yaw (
        .clk     (clk),
        .en      (stage_en.trig),
        .phase   (yaw_ph),
        .sin_val (s1),
        .cos_val (c1)
    );

    eaq_trig u_trig_pitch (
        .clk     (clk),
        .en      (stage_en.trig),
        .phase   (pitch_ph),
        .sin_val (s2),
        .cos_val (c2)
    );

    eaq_trig u_trig_roll (
        .clk     (clk),
        .en      (stage_en.trig),
        .phase   (roll_ph),
        .sin_val (s3),
        .cos_val (c3)
    );

    eaq_quat u_quat (
        .clk    (clk),
        .en     (stage_en),
        .c1     (c1),
        .s1     (s1),
        .c2     (c2),
        .s2     (s2),
        .c3     (c3),
        .s3     (s3),
        .quat_w (quat_w),
        .quat_x (quat_x),
        .quat_y (quat_y),
        .quat_z (quat_z)
    );

    assign s_axis_tready = load[0];
    assign m_axis_tvalid = valid_reg[NUM_STAGES-1];
    assign m_axis_tdata  = {quat_z, quat_y, quat_x, quat_w};

endmodule

`default_nettype wire

>>> rtl/eaq_phase.sv
// angle to half-angle phase: floor(a * 2^PHASE_BITS / 46080) modulo a full turn
`default_nettype none

module eaq_phase
    import eaq_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic signed [ANGLE_W-1:0]    angle,
    output logic         [PHASE_BITS-1:0]     phase
);

    logic [OFF_W-1:0]      angle_off;
    logic [SCALED_W-1:0]   scaled;
    logic [QUOT_W-1:0]     quot_in;
    logic [PROD_W-1:0]     prod;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;

    // adding one full turn keeps the dividend positive and leaves the phase unchanged
    always_comb
    begin
        angle_off  = {angle[ANGLE_W-1], angle} + ANGLE_OFFSET;
        scaled     = {angle_off, PHASE_BITS'(0)};
        quot_in    = scaled[SCALED_W-1:TURN_SHIFT];
        prod       = PROD_W'(quot_in) * PROD_W'(RECIP_M);
        phase_next = prod[RECIP_SHIFT +: PHASE_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            phase_reg <= phase_next;
    end

    assign phase = phase_reg;

endmodule

`default_nettype wire

>>> rtl/eaq_trig.sv
// sine and cosine of one phase from a quarter-wave rom with two read ports
`default_nettype none

module eaq_trig
    import eaq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [PHASE_BITS-1:0]    phase,
    output logic signed [SIN_W-1:0]       sin_val,
    output logic signed [SIN_W-1:0]       cos_val
);

    localparam sine_tbl_t ROM = build_sine_tbl();

    logic [1:0]              quad_s;
    logic [1:0]              quad_c;
    logic [ADDR_W-1:0]       r_ext;
    logic [ADDR_W-1:0]       addr_s;
    logic [ADDR_W-1:0]       addr_c;
    logic [FRAC_BITS-1:0]    sin_mag_reg;
    logic [FRAC_BITS-1:0]    cos_mag_reg;
    logic                    sin_neg_reg;
    logic                    cos_neg_reg;

    // cosine is a quarter turn ahead: same offset, next quadrant
    always_comb
    begin
        quad_s = phase[PHASE_BITS-1 -: 2];
        quad_c = quad_s + 2'd1;
        r_ext  = {1'b0, phase[PHASE_BITS-3:0]};
        addr_s = quad_s[0] ? ADDR_W'(QUARTER) - r_ext : r_ext;
        addr_c = quad_c[0] ? ADDR_W'(QUARTER) - r_ext : r_ext;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_mag_reg <= ROM[addr_s];
            cos_mag_reg <= ROM[addr_c];
            sin_neg_reg <= quad_s[1];
            cos_neg_reg <= quad_c[1];
        end
    end

    always_comb
    begin
        sin_val = sin_neg_reg ? -$signed({1'b0, sin_mag_reg}) : $signed({1'b0, sin_mag_reg});
        cos_val = cos_neg_reg ? -$signed({1'b0, cos_mag_reg}) : $signed({1'b0, cos_mag_reg});
    end

endmodule

`default_nettype wire

>>> rtl/eaq_quat.sv
// pair products, triple products and saturating sums of the quaternion terms
`default_nettype none

module eaq_quat
    import eaq_pkg::*;
(
    input  wire logic                     clk,
    input  wire stage_en_t                en,
    input  wire logic signed [SIN_W-1:0]  c1,
    input  wire logic signed [SIN_W-1:0]  s1,
    input  wire logic signed [SIN_W-1:0]  c2,
    input  wire logic signed [SIN_W-1:0]  s2,
    input  wire logic signed [SIN_W-1:0]  c3,
    input  wire logic signed [SIN_W-1:0]  s3,
    output logic [OUT_W-1:0]              quat_w,
    output logic [OUT_W-1:0]              quat_x,
    output logic [OUT_W-1:0]              quat_y,
    output logic [OUT_W-1:0]              quat_z
);

    localparam int MUL_W = 2 * SIN_W;

    // pair stage
    logic signed [MUL_W-1:0] cc_full, ss_full, sc_full, cs_full;
    logic signed [SIN_W-1:0] cc_reg, ss_reg, sc_reg, cs_reg;
    logic signed [SIN_W-1:0] c3_reg, s3_reg;

    // triple stage
    logic signed [MUL_W-1:0] ccc_full, sss_full, ssc_full, ccs_full;
    logic signed [MUL_W-1:0] scc_full, css_full, csc_full, scs_full;
    logic signed [SIN_W-1:0] ccc_reg, sss_reg, ssc_reg, ccs_reg;
    logic signed [SIN_W-1:0] scc_reg, css_reg, csc_reg, scs_reg;

    // sum stage
    logic signed [SUM_W-1:0] w_sum, x_sum, y_sum, z_sum;
    logic [OUT_W-1:0] w_reg, x_reg, y_reg, z_reg;

    always_comb
    begin
        cc_full = MUL_W'(c1) * MUL_W'(c2);
        ss_full = MUL_W'(s1) * MUL_W'(s2);
        sc_full = MUL_W'(s1) * MUL_W'(c2);
        cs_full = MUL_W'(c1) * MUL_W'(s2);
    end

    // dropping the low fraction bits is a floor shift
    always_ff @(posedge clk)
    begin
        if (en.pair)
        begin
            cc_reg <= cc_full[FRAC_BITS +: SIN_W];
            ss_reg <= ss_full[FRAC_BITS +: SIN_W];
            sc_reg <= sc_full[FRAC_BITS +: SIN_W];
            cs_reg <= cs_full[FRAC_BITS +: SIN_W];
            c3_reg <= c3;
            s3_reg <= s3;
        end
    end

    always_comb
    begin
        ccc_full = MUL_W'(cc_reg) * MUL_W'(c3_reg);
        sss_full = MUL_W'(ss_reg) * MUL_W'(s3_reg);
        ssc_full = MUL_W'(ss_reg) * MUL_W'(c3_reg);
        ccs_full = MUL_W'(cc_reg) * MUL_W'(s3_reg);
        scc_full = MUL_W'(sc_reg) * MUL_W'(c3_reg);
        css_full = MUL_W'(cs_reg) * MUL_W'(s3_reg);
        csc_full = MUL_W'(cs_reg) * MUL_W'(c3_reg);
        scs_full = MUL_W'(sc_reg) * MUL_W'(s3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.triple)
        begin
            ccc_reg <= ccc_full[FRAC_BITS +: SIN_W];
            sss_reg <= sss_full[FRAC_BITS +: SIN_W];
            ssc_reg <= ssc_full[FRAC_BITS +: SIN_W];
            ccs_reg <= ccs_full[FRAC_BITS +: SIN_W];
            scc_reg <= scc_full[FRAC_BITS +: SIN_W];
            css_reg <= css_full[FRAC_BITS +: SIN_W];
            csc_reg <= csc_full[FRAC_BITS +: SIN_W];
            scs_reg <= scs_full[FRAC_BITS +: SIN_W];
        end
    end

    always_comb
    begin
        w_sum = SUM_W'(ccc_reg) - SUM_W'(sss_reg);
        x_sum = SUM_W'(ssc_reg) + SUM_W'(ccs_reg);
        y_sum = SUM_W'(scc_reg) + SUM_W'(css_reg);
        z_sum = SUM_W'(csc_reg) - SUM_W'(scs_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.sum)
        begin
            w_reg <= sat_out(w_sum);
            x_reg <= sat_out(x_sum);
            y_reg <= sat_out(y_sum);
            z_reg <= sat_out(z_sum);
        end
    end

    assign quat_w = w_reg;
    assign quat_x = x_reg;
    assign quat_y = y_reg;
    assign quat_z = z_reg;

endmodule

`default_nettype wire

>>> rtl/eaq_checker.sv
// port-level checks of the euler angle to quaternion core, bound to the top level
`default_nettype none

module eaq_checker
    import eaq_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    s_axis_tready,
    input wire logic                    m_axis_tvalid,
    input wire logic                    m_axis_tready,
    input wire logic [OUT_DATA_W-1:0]   m_axis_tdata
);

    // a stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    // input back-pressure only when the pipeline is full behind a stalled output
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

    // saturation never lets a component reach the most negative code
    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:0] != 16'h8000 && m_axis_tdata[31:16] != 16'h8000
            && m_axis_tdata[47:32] != 16'h8000 && m_axis_tdata[63:48] != 16'h8000)
        else $error("quaternion component outside saturation range");

    // nothing comes out right after reset, before the pipeline could fill
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid ##1 !m_axis_tvalid ##1 !m_axis_tvalid)
        else $error("output item appeared before the pipeline could fill");

endmodule

bind euler_angles_to_quaternion_core eaq_checker u_eaq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> test/eaq_checker.sv
// checker for the euler angle to quaternion core: predicts each quaternion and compares
module eaq_scoreboard
    import eaq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic [IN_DATA_W-1:0]  s_data,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic [OUT_DATA_W-1:0] m_data,
    output int                         n_waiting,
    output int                         n_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PB = PHASE_BITS;
    localparam int FB = FRAC_BITS;
    localparam int QTR = 1 << (PB - 2);
    localparam int PHASE_MASK = (1 << PB) - 1;
    localparam longint FULL_SCALE = (longint'(1) <<< FB) - 1;
    localparam longint HALF_ANGLE_TURN = 46080;
    localparam longint Q30_ONE = longint'(1) <<< 30;
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;

    // w in the lowest bits, z in the highest
    typedef struct packed {
        logic [15:0] z;
        logic [15:0] y;
        logic [15:0] x;
        logic [15:0] w;
    } quat_t;

    longint sine_rom [QTR + 1];
    quat_t  quat_fifo [$];

    // quarter-wave sine in Q30 from a truncated series
    function automatic longint series_sine(input int unsigned k);
        logic [63:0] xu;
        longint x;
        longint x2;
        longint acc;
        longint term;
        xu = (64'(k) * (HALF_PI_Q60 >> 14) + (64'd1 << (PB + 13))) >> (PB + 14);
        x = longint'(xu);
        x2 = longint'((xu * xu) >> 30);
        acc = x;
        term = x;
        for (int n = 1; n <= 14; n++)
        begin
            term = -(term * x2) / Q30_ONE;
            term = term / longint'((2 * n) * (2 * n + 1));
            acc = acc + term;
        end
        if (acc < 0)
            acc = 0;
        if (acc > Q30_ONE)
            acc = Q30_ONE;
        return acc;
    endfunction

    // half-angle phase with floor division, then wrap
    function automatic int angle_phase(input logic signed [15:0] ang);
        longint num;
        longint q;
        num = longint'(ang) * longint'(1 << PB);
        if (num >= 0)
            q = num / HALF_ANGLE_TURN;
        else
            q = -((-num + HALF_ANGLE_TURN - 1) / HALF_ANGLE_TURN);
        return int'(q) & PHASE_MASK;
    endfunction

    function automatic longint phase_sine(input int p);
        int ph;
        int quad;
        int r;
        longint v;
        ph = p & PHASE_MASK;
        quad = ph >> (PB - 2);
        r = ph & (QTR - 1);
        v = quad[0] ? sine_rom[QTR - r] : sine_rom[r];
        return quad[1] ? -v : v;
    endfunction

    function automatic longint prod3(input longint u, input longint v, input longint t);
        return (((u * v) >>> FB) * t) >>> FB;
    endfunction

    function automatic logic [15:0] clamp_q15(input longint v);
        longint c;
        c = v;
        if (c > FULL_SCALE)
            c = FULL_SCALE;
        if (c < -FULL_SCALE)
            c = -FULL_SCALE;
        return c[15:0];
    endfunction

    function automatic quat_t angles_to_quat(input logic [IN_DATA_W-1:0] d);
        int pr;
        int py;
        int pp;
        longint c1, s1, c2, s2, c3, s3;
        quat_t q;
        pr = angle_phase(d[15:0]);
        py = angle_phase(d[31:16]);
        pp = angle_phase(d[47:32]);
        s1 = phase_sine(py);
        c1 = phase_sine(py + QTR);
        s2 = phase_sine(pp);
        c2 = phase_sine(pp + QTR);
        s3 = phase_sine(pr);
        c3 = phase_sine(pr + QTR);
        q.w = clamp_q15(prod3(c1, c2, c3) - prod3(s1, s2, s3));
        q.x = clamp_q15(prod3(s1, s2, c3) + prod3(c1, c2, s3));
        q.y = clamp_q15(prod3(s1, c2, c3) + prod3(c1, s2, s3));
        q.z = clamp_q15(prod3(c1, s2, c3) - prod3(s1, c2, s3));
        return q;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
            n_errors++;
        end
    endtask

    initial
    begin
        n_errors = 0;
        n_waiting = 0;
        for (int k = 0; k <= QTR; k++)
            sine_rom[k] = (series_sine(k) * FULL_SCALE + (longint'(1) <<< 29)) >>> 30;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_valid && m_ready)
            begin
                quat_t got;
                quat_t want;
                got = m_data;
                if (quat_fifo.size() == 0)
                begin
                    $error("result with no item waiting: %h", m_data);
                    n_errors++;
                end
                else
                begin
                    want = quat_fifo.pop_front();
                    check_field("quat_w", want.w, got.w);
                    check_field("quat_x", want.x, got.x);
                    check_field("quat_y", want.y, got.y);
                    check_field("quat_z", want.z, got.z);
                end
            end
            if (s_valid && s_ready)
                quat_fifo.push_back(angles_to_quat(s_data));
            n_waiting <= quat_fifo.size();
        end
    end

endmodule

>>> test/tb_euler_angles_to_quaternion_core.sv
// testbench top for the euler angle to quaternion core: stimulus, sink stalls and verdict
module tb_euler_angles_to_quaternion_core
    import eaq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1530;
    localparam int CALM_FIRST = 500;
    localparam int CALM_LAST = 800;
    localparam int DRAIN_AT = 1000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // roll_deg, yaw_deg, pitch_deg
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // quat_w, quat_x, quat_y, quat_z

    int  n_waiting;
    int  n_errors;
    int  items_sent;
    bit  calm;

    euler_angles_to_quaternion_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    eaq_scoreboard u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .s_data    (s_axis_tdata),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata),
        .n_waiting (n_waiting),
        .n_errors  (n_errors)
    );

    initial
        clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sink stalls at random with a chance of about 14 in a hundred, never inside the calm stretch
    always @(posedge clk)
    begin
        if (rst_n)
            m_axis_tready <= calm || ($urandom_range(99) >= 14);
    end

    // mix of nominal range, raw patterns, whole degrees and phase-step edges
    function automatic logic [15:0] random_angle();
        int mode;
        int v;
        mode = $urandom_range(99);
        if (mode < 40)
            v = int'($urandom_range(46080)) - 23040;
        else if (mode < 70)
            v = int'($urandom_range(65535)) - 32768;
        else if (mode < 85)
            v = (int'($urandom_range(720)) - 360) * 64 + int'($urandom_range(2)) - 1;
        else
            v = ((int'($urandom_range(5824)) - 2912) * 45) / 4 + int'($urandom_range(2)) - 1;
        return 16'(v);
    endfunction

    task automatic send_item(input logic [15:0] roll, input logic [15:0] yaw,
                             input logic [15:0] pitch);
        while (!calm && $urandom_range(99) < 14)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pitch, yaw, roll};
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (n_waiting != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        items_sent = 0;
        calm = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, nominal and raw extremes
        send_item(16'sd0, 16'sd0, 16'sd0);
        send_item(16'sd23040, 16'sd23040, 16'sd23040);
        send_item(-16'sd23040, -16'sd23040, -16'sd23040);
        send_item(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_item(16'h8000, 16'h8000, 16'h8000);
        send_item(16'h7FFF, 16'h8000, 16'sd0);
        send_item(16'h8000, 16'h7FFF, -16'sd1);
        send_item(16'h5555, 16'hAAAA, 16'h5555);
        // small negatives round toward minus infinity
        send_item(-16'sd1, -16'sd1, -16'sd1);
        send_item(16'sd1, 16'sd1, 16'sd1);
        send_item(-16'sd11, 16'sd0, 16'sd11);
        send_item(-16'sd12, -16'sd45, 16'sd12);
        // quarter and half turns on each axis
        send_item(16'sd5760, 16'sd0, 16'sd0);
        send_item(16'sd0, 16'sd5760, 16'sd0);
        send_item(16'sd0, 16'sd0, 16'sd5760);
        send_item(16'sd11520, 16'sd11520, 16'sd11520);
        send_item(-16'sd11520, 16'sd5760, -16'sd5760);
        send_item(16'sd2880, 16'sd2880, 16'sd2880);
        send_item(16'sd17280, -16'sd17280, 16'sd0);
        send_item(16'sd5760, 16'sd5760, -16'sd5760);
        // beyond a full turn, wraps of the half-angle
        send_item(16'sd30000, -16'sd30000, 16'sd24000);
        send_item(16'sd2, 16'sd11520, -16'sd2880);
        hold_until_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            calm = (i >= CALM_FIRST) && (i < CALM_LAST);
            if (i == DRAIN_AT)
                hold_until_drained();
            send_item(random_angle(), random_angle(), random_angle());
        end
        calm = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (n_waiting != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d angle triples: extremes, quarter turns, wraps and floor cases,",
                 items_sent);
        $display("then random angles under source gaps and sink stalls, with one full drain");
        if (n_errors == 0 && n_waiting == 0)
            $display("tb_euler_angles_to_quaternion_core: done, clean");
        else
            $display("tb_euler_angles_to_quaternion_core: done, errors");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("timeout with %0d results still outstanding", n_waiting);
        $display("tb_euler_angles_to_quaternion_core: done, errors");
        $finish;
    end

endmodule
